### rtl/dmep_pkg.sv
package dmep_pkg;

    localparam int unsigned PULSE_INTERVALS     = 10;
    localparam int unsigned RIGHT_TURN_SEGMENTS = 34;
    localparam int unsigned LEFT_TURN_SEGMENTS  = 33;
    localparam int unsigned DRIVE_LIMIT         = 400;

    localparam logic [31:0] SPEED_NUM  = 32'd3840000000;
    localparam logic [11:0] SPEED_DIV  = 12'd2249;
    localparam logic [15:0] SPEED_SAT  = 16'hFFFF;

    localparam logic [1:0] REQ_EDGE    = 2'd0;
    localparam logic [1:0] REQ_CONTROL = 2'd1;
    localparam logic [1:0] REQ_STOP    = 2'd2;

    localparam logic [1:0] DIR_FORWARD = 2'd0;
    localparam logic [1:0] DIR_CW      = 2'd1;
    localparam logic [1:0] DIR_ACW     = 2'd2;

    localparam logic [2:0] CFG_KP_L = 3'd0;
    localparam logic [2:0] CFG_KI_L = 3'd1;
    localparam logic [2:0] CFG_KD_L = 3'd2;
    localparam logic [2:0] CFG_KP_R = 3'd3;
    localparam logic [2:0] CFG_KI_R = 3'd4;
    localparam logic [2:0] CFG_KD_R = 3'd5;
    localparam logic [2:0] CFG_DIST = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PDIV,
        ST_DEN,
        ST_SDIV,
        ST_SPEED,
        ST_MUL,
        ST_MAG,
        ST_DONE
    } state_t;

endpackage

### rtl/dual_motor_encoder_pid_unit.sv
// channel | valid  | stall     | payload
// in      | valid  | stall     | req_type wheel time_us target_rpm direction
// out     | out_valid | out_stall | drive_* speed_* *_reached
// cfg     | cfg_we | -         | cfg_index cfg_data
// Stop, unused and non-closing edge items go straight to done, which sets the result valid.
// Closing edge: period divide, multiply by 2249, speed divide,
//   saturate and done; a zero period goes to done after the divide.
// Control item: per wheel three shift-add products and a clamp.
// Input is taken only while idle and the result register is empty; stall on out holds it.
// Reset clears all state and restores the gain reset values.
module dual_motor_encoder_pid_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    output logic                stall,
    input  logic [1:0]          req_type,
    input  logic                wheel,
    input  logic [31:0]         time_us,
    input  logic [15:0]         target_rpm,
    input  logic [1:0]          direction,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [9:0]   drive_left,
    output logic signed [9:0]   drive_right,
    output logic [15:0]         speed_left,
    output logic [15:0]         speed_right,
    output logic                distance_reached,
    output logic                right_turn_reached,
    output logic                left_turn_reached,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [11:0]         cfg_data
);

    dmep_pkg::state_t state_reg;

    logic [11:0] kp_reg [2];
    logic [11:0] ki_reg [2];
    logic [11:0] kd_reg [2];
    logic [7:0]  dist_target_reg;

    logic [3:0]  pulse_reg [2];
    logic [31:0] start_reg [2];
    logic [15:0] speed_reg [2];
    logic signed [17:0] prev_err_reg [2];
    logic signed [31:0] esum_reg [2];
    logic [7:0]  seg_reg;
    logic [5:0]  rturn_reg;
    logic [5:0]  lturn_reg;
    logic [2:0]  flags_reg;

    logic        w_reg;
    logic [15:0] target_reg;
    logic [1:0]  dir_reg;
    logic signed [9:0] mag_reg [2];

    // shared bit-serial divider / multiplier datapath
    logic [43:0] rem_reg;
    logic [31:0] quo_reg;
    logic [43:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic [1:0]  term_reg;
    logic signed [47:0] acc_reg;
    logic signed [35:0] mcand_reg;
    logic [11:0] mplier_reg;
    logic signed [17:0] e_reg;

    logic out_valid_reg;
    logic signed [9:0] dl_reg, dr_reg;

    assign stall = (state_reg != dmep_pkg::ST_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign drive_left = dl_reg;
    assign drive_right = dr_reg;
    assign speed_left = speed_reg[0];
    assign speed_right = speed_reg[1];
    assign distance_reached = flags_reg[0];
    assign right_turn_reached = flags_reg[1];
    assign left_turn_reached = flags_reg[2];

    logic        accept;
    assign accept = valid && !stall;

    logic [3:0]  pulse_inc;
    assign pulse_inc = pulse_reg[wheel] + 4'd1;

    logic [44:0] trial;
    assign trial = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};

    logic signed [35:0] e_ext;
    assign e_ext = {{18{e_reg[17]}}, e_reg};

    logic signed [35:0] mag_full;
    assign mag_full = acc_reg[47:12];

    logic signed [9:0] mag_sat;
    always_comb
    begin
        if (mag_full > $signed(36'(dmep_pkg::DRIVE_LIMIT)))
            mag_sat = 10'(dmep_pkg::DRIVE_LIMIT);
        else if (mag_full < -$signed(36'(dmep_pkg::DRIVE_LIMIT)))
            mag_sat = -10'(dmep_pkg::DRIVE_LIMIT);
        else
            mag_sat = mag_full[9:0];
    end

    logic signed [32:0] esum_new;
    assign esum_new = {esum_reg[w_reg][31], esum_reg[w_reg]} + {{15{e_reg[17]}}, e_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dmep_pkg::ST_IDLE;
            kp_reg[0] <= 12'd2944; ki_reg[0] <= 12'd159; kd_reg[0] <= 12'd90;
            kp_reg[1] <= 12'd2688; ki_reg[1] <= 12'd154; kd_reg[1] <= 12'd90;
            dist_target_reg <= '0;
            for (int i = 0; i < 2; i++)
            begin
                pulse_reg[i] <= '0;
                start_reg[i] <= '0;
                speed_reg[i] <= '0;
                prev_err_reg[i] <= '0;
                esum_reg[i] <= '0;
                mag_reg[i] <= '0;
            end
            seg_reg <= '0;
            rturn_reg <= '0;
            lturn_reg <= '0;
            flags_reg <= '0;
            w_reg <= 1'b0;
            target_reg <= '0;
            dir_reg <= '0;
            rem_reg <= '0;
            quo_reg <= '0;
            dvs_reg <= '0;
            cnt_reg <= '0;
            term_reg <= '0;
            acc_reg <= '0;
            mcand_reg <= '0;
            mplier_reg <= '0;
            e_reg <= '0;
            dl_reg <= '0;
            dr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    dmep_pkg::CFG_KP_L: kp_reg[0] <= cfg_data;
                    dmep_pkg::CFG_KI_L: ki_reg[0] <= cfg_data;
                    dmep_pkg::CFG_KD_L: kd_reg[0] <= cfg_data;
                    dmep_pkg::CFG_KP_R: kp_reg[1] <= cfg_data;
                    dmep_pkg::CFG_KI_R: ki_reg[1] <= cfg_data;
                    dmep_pkg::CFG_KD_R: kd_reg[1] <= cfg_data;
                    dmep_pkg::CFG_DIST: dist_target_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                dmep_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        w_reg <= wheel;
                        target_reg <= target_rpm;
                        dir_reg <= direction;
                        dl_reg <= '0;
                        dr_reg <= '0;
                        state_reg <= dmep_pkg::ST_DONE;
                        case (req_type)
                            dmep_pkg::REQ_EDGE:
                            begin
                                pulse_reg[wheel] <= pulse_inc;
                                if (pulse_inc == 4'd1)
                                    start_reg[wheel] <= time_us;
                                else if (pulse_inc == 4'(dmep_pkg::PULSE_INTERVALS + 1))
                                begin
                                    pulse_reg[wheel] <= '0;
                                    quo_reg <= time_us - start_reg[wheel];
                                    rem_reg <= '0;
                                    dvs_reg <= 44'(dmep_pkg::PULSE_INTERVALS);
                                    cnt_reg <= '0;
                                    state_reg <= dmep_pkg::ST_PDIV;
                                    if (!wheel)
                                    begin
                                        if (dist_target_reg != 8'd0
                                            && seg_reg + 8'd1 == dist_target_reg)
                                        begin
                                            flags_reg[0] <= 1'b1;
                                            seg_reg <= '0;
                                        end
                                        else
                                            seg_reg <= seg_reg + 8'd1;
                                    end
                                    else
                                    begin
                                        if (rturn_reg + 6'd1 ==
                                            6'(dmep_pkg::RIGHT_TURN_SEGMENTS))
                                        begin
                                            flags_reg[1] <= 1'b1;
                                            rturn_reg <= '0;
                                        end
                                        else
                                            rturn_reg <= rturn_reg + 6'd1;
                                        if (lturn_reg + 6'd1 ==
                                            6'(dmep_pkg::LEFT_TURN_SEGMENTS))
                                        begin
                                            flags_reg[2] <= 1'b1;
                                            lturn_reg <= '0;
                                        end
                                        else
                                            lturn_reg <= lturn_reg + 6'd1;
                                    end
                                end
                            end
                            dmep_pkg::REQ_CONTROL:
                            begin
                                w_reg <= 1'b0;
                                e_reg <= 18'({2'b00, target_rpm}) - 18'({2'b00, speed_reg[0]});
                                acc_reg <= '0;
                                term_reg <= '0;
                                cnt_reg <= '0;
                                state_reg <= dmep_pkg::ST_MUL;
                                mcand_reg <= 36'(signed'(18'({2'b00, target_rpm})
                                    - 18'({2'b00, speed_reg[0]})));
                                mplier_reg <= kp_reg[0];
                            end
                            dmep_pkg::REQ_STOP:
                            begin
                                pulse_reg[0] <= '0;
                                pulse_reg[1] <= '0;
                                seg_reg <= '0;
                                rturn_reg <= '0;
                                lturn_reg <= '0;
                                flags_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                dmep_pkg::ST_PDIV:
                begin
                    // restoring divide, one quotient bit a cycle
                    if (!trial[44])
                        rem_reg <= trial[43:0];
                    else
                        rem_reg <= {rem_reg[42:0], quo_reg[31]};
                    quo_reg <= {quo_reg[30:0], !trial[44]};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31)
                    begin
                        cnt_reg <= '0;
                        acc_reg <= '0;
                        state_reg <= dmep_pkg::ST_DEN;
                    end
                end
                dmep_pkg::ST_DEN:
                begin
                    // period * 2249, shift-add over the 12 multiplier bits
                    if (quo_reg == 32'd0)
                    begin
                        speed_reg[w_reg] <= '0;
                        state_reg <= dmep_pkg::ST_DONE;
                    end
                    else
                    begin
                        if (dmep_pkg::SPEED_DIV[cnt_reg[3:0]])
                            dvs_reg <= (cnt_reg == 6'd0 ? 44'd0 : dvs_reg)
                                + (44'(quo_reg) << cnt_reg[3:0]);
                        else if (cnt_reg == 6'd0)
                            dvs_reg <= '0;
                        cnt_reg <= cnt_reg + 6'd1;
                        if (cnt_reg == 6'd11)
                        begin
                            cnt_reg <= '0;
                            quo_reg <= dmep_pkg::SPEED_NUM;
                            rem_reg <= '0;
                            state_reg <= dmep_pkg::ST_SDIV;
                        end
                    end
                end
                dmep_pkg::ST_SDIV:
                begin
                    if (!trial[44])
                        rem_reg <= trial[43:0];
                    else
                        rem_reg <= {rem_reg[42:0], quo_reg[31]};
                    quo_reg <= {quo_reg[30:0], !trial[44]};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31)
                        state_reg <= dmep_pkg::ST_SPEED;
                end
                dmep_pkg::ST_SPEED:
                begin
                    speed_reg[w_reg] <= (quo_reg[31:16] != 16'd0) ? dmep_pkg::SPEED_SAT
                                                                  : quo_reg[15:0];
                    state_reg <= dmep_pkg::ST_DONE;
                end
                dmep_pkg::ST_MUL:
                begin
                    // signed multiplicand times unsigned 12-bit gain, one bit a cycle
                    if (mplier_reg[0])
                        acc_reg <= acc_reg + (48'(mcand_reg) <<< cnt_reg[3:0]);
                    mplier_reg <= {1'b0, mplier_reg[11:1]};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd11)
                    begin
                        cnt_reg <= '0;
                        term_reg <= term_reg + 2'd1;
                        case (term_reg)
                            2'd0:
                            begin
                                mcand_reg <= e_ext - 36'(prev_err_reg[w_reg]);
                                mplier_reg <= kd_reg[w_reg];
                            end
                            2'd1:
                            begin
                                mcand_reg <= 36'(esum_reg[w_reg]);
                                mplier_reg <= ki_reg[w_reg];
                            end
                            default: state_reg <= dmep_pkg::ST_MAG;
                        endcase
                    end
                end
                dmep_pkg::ST_MAG:
                begin
                    mag_reg[w_reg] <= mag_sat;
                    prev_err_reg[w_reg] <= e_reg;
                    if (esum_new[32] != esum_new[31])
                        esum_reg[w_reg] <= esum_new[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
                    else
                        esum_reg[w_reg] <= esum_new[31:0];
                    if (!w_reg)
                    begin
                        w_reg <= 1'b1;
                        e_reg <= 18'({2'b00, target_reg}) - 18'({2'b00, speed_reg[1]});
                        mcand_reg <= 36'(signed'(18'({2'b00, target_reg})
                            - 18'({2'b00, speed_reg[1]})));
                        mplier_reg <= kp_reg[1];
                        acc_reg <= '0;
                        term_reg <= '0;
                        cnt_reg <= '0;
                        state_reg <= dmep_pkg::ST_MUL;
                    end
                    else
                    begin
                        case (dir_reg)
                            dmep_pkg::DIR_FORWARD:
                            begin
                                dl_reg <= -mag_reg[0]; dr_reg <= -mag_sat;
                            end
                            dmep_pkg::DIR_CW:
                            begin
                                dl_reg <= -mag_reg[0]; dr_reg <= mag_sat;
                            end
                            dmep_pkg::DIR_ACW:
                            begin
                                dl_reg <= mag_reg[0]; dr_reg <= -mag_sat;
                            end
                            default:
                            begin
                                dl_reg <= mag_reg[0]; dr_reg <= mag_sat;
                            end
                        endcase
                        state_reg <= dmep_pkg::ST_DONE;
                    end
                end
                dmep_pkg::ST_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg <= dmep_pkg::ST_IDLE;
                end
                default: state_reg <= dmep_pkg::ST_IDLE;
            endcase
        end
    end

endmodule
